// ----- sv/ssf_pkg.sv -----
// ssf_pkg: shared types, constants and helpers for the state-space filter step.
// Standalone package; used by every module of the block.
package ssf_pkg;

  // Storage layout limits (fixed by the field widths)
  localparam int MAXS = 4;
  localparam int MAXI = 2;
  localparam int MAXO = 2;

  // Defaults for the top-level dimension parameters
  localparam int NUM_STATES_DEF  = 4;
  localparam int NUM_INPUTS_DEF  = 2;
  localparam int NUM_OUTPUTS_DEF = 2;

  // Datapath widths
  localparam int COEF_W     = 24;
  localparam int SIG_W      = 32;
  localparam int PROD_W     = COEF_W + SIG_W;
  localparam int FRAC_SHIFT = 20;
  localparam int RND_W      = PROD_W - FRAC_SHIFT;
  localparam int ACC_W      = RND_W + 4;

  // Coefficient store: A, B, C, D packed one after another
  localparam int BASE_A     = 0;
  localparam int BASE_B     = BASE_A + MAXS * MAXS;
  localparam int BASE_C     = BASE_B + MAXS * MAXI;
  localparam int BASE_D     = BASE_C + MAXO * MAXS;
  localparam int COEF_DEPTH = BASE_D + MAXO * MAXI;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  // State store: two banks of MAXS entries, old and new state
  localparam int ST_DEPTH = 2 * MAXS;
  localparam int ST_AW    = $clog2(ST_DEPTH);

  // Sequencer counters
  localparam int ROW_W  = $clog2(MAXS);
  localparam int TERM_W = $clog2(MAXS + MAXI + 1);

  // Function codes
  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_SAMPLE = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  // Matrix codes
  localparam logic [1:0] MAT_A = 2'd0;
  localparam logic [1:0] MAT_B = 2'd1;
  localparam logic [1:0] MAT_C = 2'd2;
  localparam logic [1:0] MAT_D = 2'd3;

  // Input request payload
  typedef struct packed {
    logic [1:0]               func;
    logic [1:0]               coef_matrix;
    logic [1:0]               coef_row;
    logic [1:0]               coef_col;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SIG_W-1:0]  u_first;
    logic signed [SIG_W-1:0]  u_second;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic signed [SIG_W-1:0] y_first;
    logic signed [SIG_W-1:0] y_second;
    logic                    saturated;
  } out_rsp_t;

  // Per-term control that travels with the MAC pipeline
  typedef struct packed {
    logic             first;
    logic             last;
    logic             is_out;
    logic [ROW_W-1:0] row;
  } mac_tag_t;

  // One multiply-accumulate term
  typedef struct packed {
    logic                     valid;
    mac_tag_t                 tag;
    logic signed [COEF_W-1:0] coef;
    logic signed [SIG_W-1:0]  sig;
  } mac_req_t;

  // Finished row sum
  typedef struct packed {
    logic                    valid;
    logic                    is_out;
    logic [ROW_W-1:0]        row;
    logic signed [SIG_W-1:0] value;
    logic                    sat;
  } mac_rsp_t;

  // Coefficient store address of one matrix element
  function automatic logic [COEF_AW-1:0] coef_addr(logic [1:0] mat, logic [1:0] row,
                                                   logic [1:0] col);
    logic [COEF_AW-1:0] a;
    unique case (mat)
      MAT_A: a = COEF_AW'(BASE_A + int'(row) * MAXS + int'(col));
      MAT_B: a = COEF_AW'(BASE_B + int'(row) * MAXI + int'(col));
      MAT_C: a = COEF_AW'(BASE_C + int'(row) * MAXS + int'(col));
      MAT_D: a = COEF_AW'(BASE_D + int'(row) * MAXI + int'(col));
    endcase
    return a;
  endfunction

endpackage

// ----- sv/state_space_filter_step.sv -----
// state_space_filter_step: top level, sequencer and result register.
// Depends on ssf_pkg, ssf_coef_mem, ssf_state_mem and ssf_mac.
//
// Discrete linear state-space step in fixed point. A write request stores one
// Q4.20 coefficient of A, B, C or D (out-of-range row/column is dropped); a
// clear request zeroes the state; neither gives a result. A sample request
// computes x' = A*x + B*u, then y = C*x' + D*u on the fresh state, and
// returns y with a flag set if any row sum saturated. All terms go through
// one shared multiply-accumulate unit, one term per cycle; besides the terms,
// a sample spends time on two pipeline drains of the MAC and state store plus
// the result hand-off. The input side stalls until the result is handed to
// the result register, which holds the last result until it is taken.
module state_space_filter_step #(
  parameter int NUM_STATES  = ssf_pkg::NUM_STATES_DEF,
  parameter int NUM_INPUTS  = ssf_pkg::NUM_INPUTS_DEF,
  parameter int NUM_OUTPUTS = ssf_pkg::NUM_OUTPUTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssf_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ssf_pkg::out_rsp_t out_data
);

  localparam int TERMS = NUM_STATES + NUM_INPUTS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_XRUN   = 3'd1;
  localparam logic [2:0] ST_XDRAIN = 3'd2;
  localparam logic [2:0] ST_YRUN   = 3'd3;
  localparam logic [2:0] ST_YDRAIN = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  localparam logic [ssf_pkg::TERM_W-1:0] LAST_TERM = ssf_pkg::TERM_W'(TERMS - 1);
  localparam logic [ssf_pkg::TERM_W-1:0] NS_TERM   = ssf_pkg::TERM_W'(NUM_STATES);
  localparam logic [ssf_pkg::ROW_W-1:0]  LAST_XROW = ssf_pkg::ROW_W'(NUM_STATES - 1);
  localparam logic [ssf_pkg::ROW_W-1:0]  LAST_YROW = ssf_pkg::ROW_W'(NUM_OUTPUTS - 1);

  logic [2:0]                     st_r, st_nxt;
  logic [ssf_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [ssf_pkg::TERM_W-1:0]     term_r, term_nxt;
  logic                           bank_r, bank_nxt;
  logic signed [ssf_pkg::SIG_W-1:0] u_r [ssf_pkg::MAXI];
  logic signed [ssf_pkg::SIG_W-1:0] y_r [ssf_pkg::MAXO];
  logic                           sat_r;
  logic                           out_valid_r;
  ssf_pkg::out_rsp_t              out_data_r;

  logic                           in_acc;
  logic                           in_bounds;
  logic                           coef_wr;
  logic                           st_clr;
  logic                           st_wr;
  logic                           issue;
  logic                           is_u;
  logic [1:0]                     iss_mat;
  logic [1:0]                     iss_col;
  logic [ssf_pkg::COEF_AW-1:0]    coef_wr_addr;
  logic [ssf_pkg::COEF_AW-1:0]    coef_rd_addr;
  logic signed [ssf_pkg::COEF_W-1:0] coef_rd;
  logic signed [ssf_pkg::SIG_W-1:0]  st_rd;
  logic                           x_done;
  logic                           y_done;
  logic                           out_free;

  // Issue info delayed to line up with the memory read data
  logic                           d_vld_r;
  ssf_pkg::mac_tag_t              d_tag_r;
  logic                           d_is_u_r;
  logic [$clog2(ssf_pkg::MAXI)-1:0] d_uidx_r;
  ssf_pkg::mac_tag_t              iss_tag;
  ssf_pkg::mac_req_t              mac_req;
  ssf_pkg::mac_rsp_t              mac_rsp;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && (st_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Coefficient write decode with dimension check
  always_comb begin
    unique case (in_data.coef_matrix)
      ssf_pkg::MAT_A: in_bounds = (3'(in_data.coef_row) < 3'(NUM_STATES)) &&
                                  (3'(in_data.coef_col) < 3'(NUM_STATES));
      ssf_pkg::MAT_B: in_bounds = (3'(in_data.coef_row) < 3'(NUM_STATES)) &&
                                  (3'(in_data.coef_col) < 3'(NUM_INPUTS));
      ssf_pkg::MAT_C: in_bounds = (3'(in_data.coef_row) < 3'(NUM_OUTPUTS)) &&
                                  (3'(in_data.coef_col) < 3'(NUM_STATES));
      ssf_pkg::MAT_D: in_bounds = (3'(in_data.coef_row) < 3'(NUM_OUTPUTS)) &&
                                  (3'(in_data.coef_col) < 3'(NUM_INPUTS));
    endcase
    coef_wr      = in_acc && (in_data.func == ssf_pkg::FN_WRITE) && in_bounds;
    st_clr       = in_acc && (in_data.func == ssf_pkg::FN_CLEAR);
    coef_wr_addr = ssf_pkg::coef_addr(in_data.coef_matrix, in_data.coef_row,
                                      in_data.coef_col);
  end

  // Term issue: coefficient and state addresses for the current term
  always_comb begin
    issue   = (st_r == ST_XRUN) || (st_r == ST_YRUN);
    is_u    = (term_r >= NS_TERM);
    iss_col = is_u ? 2'(term_r - NS_TERM) : term_r[1:0];
    if (st_r == ST_YRUN) begin
      iss_mat = is_u ? ssf_pkg::MAT_D : ssf_pkg::MAT_C;
    end else begin
      iss_mat = is_u ? ssf_pkg::MAT_B : ssf_pkg::MAT_A;
    end
    coef_rd_addr   = ssf_pkg::coef_addr(iss_mat, row_r, iss_col);
    iss_tag.first  = (term_r == '0);
    iss_tag.last   = (term_r == LAST_TERM);
    iss_tag.is_out = (st_r == ST_YRUN);
    iss_tag.row    = row_r;
  end

  always_ff @(posedge clk) begin
    d_tag_r  <= iss_tag;
    d_is_u_r <= is_u;
    d_uidx_r <= iss_col[$clog2(ssf_pkg::MAXI)-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= issue;
    end
  end

  // Operand select: state from memory or input element from register
  always_comb begin
    mac_req.valid = d_vld_r;
    mac_req.tag   = d_tag_r;
    mac_req.coef  = coef_rd;
    mac_req.sig   = d_is_u_r ? u_r[d_uidx_r] : st_rd;
  end

  // Row results: state rows go to the new bank, output rows to y
  assign st_wr  = mac_rsp.valid && !mac_rsp.is_out;
  assign x_done = st_wr && (mac_rsp.row == LAST_XROW);
  assign y_done = mac_rsp.valid && mac_rsp.is_out && (mac_rsp.row == LAST_YROW);

  ssf_coef_mem u_coef_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_wr),
    .wr_addr (coef_wr_addr),
    .wr_data (in_data.coef_value),
    .rd_addr (coef_rd_addr),
    .rd_data (coef_rd)
  );

  ssf_state_mem u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (st_clr),
    .wr_en   (st_wr),
    .wr_addr ({!bank_r, mac_rsp.row}),
    .wr_data (mac_rsp.value),
    .rd_addr ({bank_r, term_r[ssf_pkg::ROW_W-1:0]}),
    .rd_data (st_rd)
  );

  ssf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    row_nxt  = row_r;
    term_nxt = term_r;
    bank_nxt = bank_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc && (in_data.func == ssf_pkg::FN_SAMPLE)) begin
          st_nxt   = ST_XRUN;
          row_nxt  = '0;
          term_nxt = '0;
        end
      end
      ST_XRUN, ST_YRUN: begin
        if (term_r == LAST_TERM) begin
          term_nxt = '0;
          if (row_r == ((st_r == ST_XRUN) ? LAST_XROW : LAST_YROW)) begin
            row_nxt = '0;
            st_nxt  = (st_r == ST_XRUN) ? ST_XDRAIN : ST_YDRAIN;
          end else begin
            row_nxt = row_r + ssf_pkg::ROW_W'(1);
          end
        end else begin
          term_nxt = term_r + ssf_pkg::TERM_W'(1);
        end
      end
      ST_XDRAIN: begin
        if (x_done) begin
          bank_nxt = !bank_r;
          st_nxt   = ST_YRUN;
        end
      end
      ST_YDRAIN: begin
        if (y_done) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      row_r  <= '0;
      term_r <= '0;
      bank_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      row_r  <= row_nxt;
      term_r <= term_nxt;
      bank_r <= bank_nxt;
    end
  end

  // Sample operands, output rows and saturation flag
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.func == ssf_pkg::FN_SAMPLE)) begin
      u_r[0] <= in_data.u_first;
      u_r[1] <= in_data.u_second;
      y_r[0] <= '0;
      y_r[1] <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (mac_rsp.valid && mac_rsp.is_out) begin
        y_r[mac_rsp.row[$clog2(ssf_pkg::MAXO)-1:0]] <= mac_rsp.value;
      end
      if (mac_rsp.valid) begin
        sat_r <= sat_r | mac_rsp.sat;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_FIN) && out_free) begin
      out_data_r.y_first   <= y_r[0];
      out_data_r.y_second  <= y_r[1];
      out_data_r.saturated <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A new result appears only out of the final hand-off state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_FIN)
    else $error("result raised outside final state");

  // The MAC never finishes a row while the sequencer is idle
  a_no_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !mac_rsp.valid)
    else $error("row result while idle");

  // New state is written only during the state-update phase
  a_st_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr |-> (st_r == ST_XRUN) || (st_r == ST_XDRAIN))
    else $error("state write outside update phase");

  // The state bank stays put while output rows are computed
  a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_YRUN) || (st_r == ST_YDRAIN) |=> $stable(bank_r))
    else $error("state bank changed during output phase");
`endif

endmodule

// ----- sv/ssf_coef_mem.sv -----
// ssf_coef_mem: synchronous coefficient store (A, B, C, D) with per-entry valid bits.
// Uses ssf_pkg for widths and depth.
module ssf_coef_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [ssf_pkg::COEF_AW-1:0]       wr_addr,
  input  logic signed [ssf_pkg::COEF_W-1:0] wr_data,
  input  logic [ssf_pkg::COEF_AW-1:0]       rd_addr,
  output logic signed [ssf_pkg::COEF_W-1:0] rd_data
);

  logic signed [ssf_pkg::COEF_W-1:0] mem [ssf_pkg::COEF_DEPTH];
  logic [ssf_pkg::COEF_DEPTH-1:0]    vld_r;
  logic signed [ssf_pkg::COEF_W-1:0] rd_q_r;
  logic                              rd_vld_r;

  // Array write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Valid bits: never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- sv/ssf_state_mem.sv -----
// ssf_state_mem: two-bank synchronous state store with valid bits and bulk clear.
// Uses ssf_pkg for widths and depth.
module ssf_state_mem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clr,
  input  logic                             wr_en,
  input  logic [ssf_pkg::ST_AW-1:0]        wr_addr,
  input  logic signed [ssf_pkg::SIG_W-1:0] wr_data,
  input  logic [ssf_pkg::ST_AW-1:0]        rd_addr,
  output logic signed [ssf_pkg::SIG_W-1:0] rd_data
);

  logic signed [ssf_pkg::SIG_W-1:0] mem [ssf_pkg::ST_DEPTH];
  logic [ssf_pkg::ST_DEPTH-1:0]     vld_r;
  logic signed [ssf_pkg::SIG_W-1:0] rd_q_r;
  logic                             rd_vld_r;

  // Array write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Valid bits: reset and clear zero the whole state at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- sv/ssf_mac.sv -----
// ssf_mac: shared multiply, round-half-up, accumulate and saturate pipeline.
// Uses ssf_pkg for the term and row-sum structs.
module ssf_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  ssf_pkg::mac_req_t req,
  output ssf_pkg::mac_rsp_t rsp
);

  localparam logic signed [ssf_pkg::PROD_W-1:0] RND_BIAS =
    ssf_pkg::PROD_W'(1) <<< (ssf_pkg::FRAC_SHIFT - 1);

  logic                               p_vld_r;
  ssf_pkg::mac_tag_t                  p_tag_r;
  logic signed [ssf_pkg::PROD_W-1:0]  prod_r;
  logic signed [ssf_pkg::PROD_W-1:0]  biased;
  logic signed [ssf_pkg::RND_W-1:0]   rnd;
  logic signed [ssf_pkg::ACC_W-1:0]   acc_r;
  logic signed [ssf_pkg::ACC_W-1:0]   acc_nxt;
  logic                               ovf;
  ssf_pkg::mac_rsp_t                  rsp_r;

  // Stage 1: exact product
  always_ff @(posedge clk) begin
    prod_r  <= req.coef * req.sig;
    p_tag_r <= req.tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= req.valid;
    end
  end

  // Round to Q20.16 (floor after bias) and accumulate
  always_comb begin
    biased  = prod_r + RND_BIAS;
    rnd     = biased[ssf_pkg::PROD_W-1:ssf_pkg::FRAC_SHIFT];
    acc_nxt = p_tag_r.first ? ssf_pkg::ACC_W'(rnd) : acc_r + ssf_pkg::ACC_W'(rnd);
    ovf     = acc_nxt[ssf_pkg::ACC_W-1:ssf_pkg::SIG_W-1] !=
              {(ssf_pkg::ACC_W - ssf_pkg::SIG_W + 1){acc_nxt[ssf_pkg::SIG_W-1]}};
  end

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Stage 2: saturated row sum on the last term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_r.valid <= 1'b0;
    end else begin
      rsp_r.valid <= p_vld_r && p_tag_r.last;
    end
    rsp_r.is_out <= p_tag_r.is_out;
    rsp_r.row    <= p_tag_r.row;
    rsp_r.sat    <= ovf;
    if (!ovf) begin
      rsp_r.value <= acc_nxt[ssf_pkg::SIG_W-1:0];
    end else if (acc_nxt[ssf_pkg::ACC_W-1]) begin
      rsp_r.value <= {1'b1, {(ssf_pkg::SIG_W - 1){1'b0}}};
    end else begin
      rsp_r.value <= {1'b0, {(ssf_pkg::SIG_W - 1){1'b1}}};
    end
  end

  assign rsp = rsp_r;

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for state_space_filter_step, with a clocked driver,
// a clocked monitor and a bit-exact state-space predictor.
// Depends on ssf_pkg and the state_space_filter_step RTL.
module tb_top;
  import ssf_pkg::*;

  localparam int N_ST  = NUM_STATES_DEF;
  localparam int N_IN  = NUM_INPUTS_DEF;
  localparam int N_OUT = NUM_OUTPUTS_DEF;

  // func code that the block ignores
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 310;

  // One queued request plus its pacing
  typedef struct {
    in_req_t req;
    bit      hold;
    int      tx_pct;
    int      rx_pct;
  } pend_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  pend_t    pending[$];
  pend_t    head_item;
  out_rsp_t expected_y[$];
  int       rx_pct = 0;
  int       errors = 0;
  int       quiet_cycles = 0;

  // Predictor state: coefficients (Q4.20) and state vector (Q16.16)
  logic signed [COEF_W-1:0] a_coef[MAXS][MAXS];
  logic signed [COEF_W-1:0] b_coef[MAXS][MAXI];
  logic signed [COEF_W-1:0] c_coef[MAXO][MAXS];
  logic signed [COEF_W-1:0] d_coef[MAXO][MAXI];
  logic signed [SIG_W-1:0]  x_vec[MAXS];

  state_space_filter_step #(
    .NUM_STATES (N_ST),
    .NUM_INPUTS (N_IN),
    .NUM_OUTPUTS(N_OUT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Q20.36 product rounded half up to Q20.16
  function automatic longint scaled_term(logic signed [COEF_W-1:0] c,
                                         logic signed [SIG_W-1:0] s);
    longint p;
    p = longint'(c) * longint'(s) + (longint'(1) <<< 19);
    return p >>> FRAC_SHIFT;
  endfunction

  function automatic logic signed [SIG_W-1:0] clamp32(longint v, inout bit flag);
    if (v > longint'(32'sh7fffffff)) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -longint'(64'sh80000000)) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[SIG_W-1:0];
  endfunction

  // Apply one accepted request to the predictor; a sample queues its result
  task automatic apply_request(in_req_t r);
    logic signed [SIG_W-1:0] u[MAXI];
    logic signed [SIG_W-1:0] xn[MAXS];
    logic signed [SIG_W-1:0] y[MAXO];
    longint acc;
    bit sat;
    out_rsp_t rsp;
    sat = 1'b0;
    u[0] = r.u_first;
    u[1] = (N_IN > 1) ? r.u_second : '0;
    case (r.func)
      FN_WRITE: begin
        if (r.coef_matrix == MAT_A && r.coef_row < N_ST && r.coef_col < N_ST)
          a_coef[r.coef_row][r.coef_col] = r.coef_value;
        else if (r.coef_matrix == MAT_B && r.coef_row < N_ST && r.coef_col < N_IN)
          b_coef[r.coef_row][r.coef_col] = r.coef_value;
        else if (r.coef_matrix == MAT_C && r.coef_row < N_OUT && r.coef_col < N_ST)
          c_coef[r.coef_row][r.coef_col] = r.coef_value;
        else if (r.coef_matrix == MAT_D && r.coef_row < N_OUT && r.coef_col < N_IN)
          d_coef[r.coef_row][r.coef_col] = r.coef_value;
      end
      FN_CLEAR: begin
        for (int i = 0; i < MAXS; i++) x_vec[i] = '0;
      end
      FN_SAMPLE: begin
        // state update first, output then uses the new state
        for (int i = 0; i < MAXS; i++) begin
          acc = 0;
          if (i < N_ST) begin
            for (int j = 0; j < N_ST; j++) acc += scaled_term(a_coef[i][j], x_vec[j]);
            for (int j = 0; j < N_IN; j++) acc += scaled_term(b_coef[i][j], u[j]);
            xn[i] = clamp32(acc, sat);
          end else begin
            xn[i] = '0;
          end
        end
        for (int i = 0; i < MAXS; i++) x_vec[i] = xn[i];
        for (int i = 0; i < MAXO; i++) begin
          acc = 0;
          if (i < N_OUT) begin
            for (int j = 0; j < N_ST; j++) acc += scaled_term(c_coef[i][j], x_vec[j]);
            for (int j = 0; j < N_IN; j++) acc += scaled_term(d_coef[i][j], u[j]);
            y[i] = clamp32(acc, sat);
          end else begin
            y[i] = '0;
          end
        end
        rsp.y_first   = y[0];
        rsp.y_second  = y[1];
        rsp.saturated = sat;
        expected_y.push_back(rsp);
      end
      default: ;
    endcase
  endtask

  // Mostly small signals, sometimes full range
  function automatic logic signed [SIG_W-1:0] rand_signal();
    if ($urandom_range(99) < 60) return SIG_W'(int'($urandom_range(524288)) - 262144);
    return SIG_W'($urandom);
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    if ($urandom_range(99) < 70) return COEF_W'(int'($urandom_range(524288)) - 262144);
    return COEF_W'($urandom);
  endfunction

  // Every field random, then func forced
  function automatic in_req_t make_req(logic [1:0] fn);
    in_req_t r;
    r.func        = fn;
    r.coef_matrix = 2'($urandom);
    r.coef_row    = 2'($urandom);
    r.coef_col    = 2'($urandom);
    r.coef_value  = rand_coef();
    r.u_first     = rand_signal();
    r.u_second    = rand_signal();
    return r;
  endfunction

  function automatic in_req_t wr_req(logic [1:0] mat, logic [1:0] row, logic [1:0] col,
                                     logic signed [COEF_W-1:0] val);
    in_req_t r;
    r = make_req(FN_WRITE);
    r.coef_matrix = mat;
    r.coef_row    = row;
    r.coef_col    = col;
    r.coef_value  = val;
    return r;
  endfunction

  function automatic in_req_t smp_req(logic signed [SIG_W-1:0] u0,
                                      logic signed [SIG_W-1:0] u1);
    in_req_t r;
    r = make_req(FN_SAMPLE);
    r.u_first  = u0;
    r.u_second = u1;
    return r;
  endfunction

  task automatic queue_req(in_req_t r, bit hold, int tx, int rx);
    pend_t p;
    p.req    = r;
    p.hold   = hold;
    p.tx_pct = tx;
    p.rx_pct = rx;
    pending.push_back(p);
  endtask

  // One random phase: writes to all of A, then bursts of requests
  task automatic queue_phase(int tx, int rx);
    int cnt;
    int pick;
    int burst;
    in_req_t r;
    cnt = 0;
    for (int i = 0; i < N_ST; i++) begin
      for (int j = 0; j < N_ST; j++) begin
        queue_req(wr_req(MAT_A, 2'(i), 2'(j), COEF_W'(int'($urandom_range(262144)) - 131072)),
                  (i == 0 && j == 0), tx, rx);
        cnt++;
      end
    end
    while (cnt < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 14) begin
        burst = $urandom_range(6, 1);
        for (int k = 0; k < burst; k++) begin
          r = make_req(FN_WRITE);
          if ($urandom_range(99) < 80) begin
            // in-dimension write
            r.coef_row = (r.coef_matrix inside {MAT_A, MAT_B}) ?
                         2'($urandom_range(N_ST - 1)) : 2'($urandom_range(N_OUT - 1));
            r.coef_col = (r.coef_matrix inside {MAT_A, MAT_C}) ?
                         2'($urandom_range(N_ST - 1)) : 2'($urandom_range(N_IN - 1));
            cnt++;
          end
          queue_req(r, 1'b0, tx, rx);
        end
      end else if (pick < 19) begin
        queue_req(make_req(FN_CLEAR), 1'b0, tx, rx);
        cnt++;
      end else if (pick < 22) begin
        queue_req(make_req(FN_UNUSED), 1'b0, tx, rx);
      end else begin
        burst = $urandom_range(8, 1);
        for (int k = 0; k < burst; k++) queue_req(make_req(FN_SAMPLE), 1'b0, tx, rx);
        cnt += burst;
      end
    end
  endtask

  // Driver: predicts on acceptance, then presents the next request or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(in_data);
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && (!pending[0].hold || expected_y.size() == 0) &&
            $urandom_range(99) >= pending[0].tx_pct) begin
          head_item = pending.pop_front();
          rx_pct   = head_item.rx_pct;
          in_data  <= head_item.req;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_y.size() == 0) begin
          $display("%0t: unexpected result y_first=%0d y_second=%0d saturated=%0b",
                   $time, out_data.y_first, out_data.y_second, out_data.saturated);
          errors++;
        end else begin
          if (out_data.y_first !== expected_y[0].y_first) begin
            $display("%0t: y_first expected %0d actual %0d", $time,
                     expected_y[0].y_first, out_data.y_first);
            errors++;
          end
          if (out_data.y_second !== expected_y[0].y_second) begin
            $display("%0t: y_second expected %0d actual %0d", $time,
                     expected_y[0].y_second, out_data.y_second);
            errors++;
          end
          if (out_data.saturated !== expected_y[0].saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     expected_y[0].saturated, out_data.saturated);
            errors++;
          end
          void'(expected_y.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // Watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MAXS; i++) begin
      x_vec[i] = '0;
      for (int j = 0; j < MAXS; j++) a_coef[i][j] = '0;
      for (int j = 0; j < MAXI; j++) b_coef[i][j] = '0;
    end
    for (int i = 0; i < MAXO; i++) begin
      for (int j = 0; j < MAXS; j++) c_coef[i][j] = '0;
      for (int j = 0; j < MAXI; j++) d_coef[i][j] = '0;
    end

    // Directed: coefficient extremes, ignored writes, signal extremes, clear, unused func
    queue_req(wr_req(MAT_A, 2'd0, 2'd0, 24'sh7fffff), 1'b0, 0, 0);
    queue_req(wr_req(MAT_A, 2'd3, 2'd3, 24'sh800000), 1'b0, 0, 0);
    queue_req(wr_req(MAT_B, 2'd0, 2'd0, 24'sh100000), 1'b0, 0, 0);
    queue_req(wr_req(MAT_B, 2'd3, 2'd1, -24'sh080000), 1'b0, 0, 0);
    queue_req(wr_req(MAT_C, 2'd0, 2'd0, 24'sh100000), 1'b0, 0, 0);
    queue_req(wr_req(MAT_C, 2'd1, 2'd3, 24'sh7fffff), 1'b0, 0, 0);
    queue_req(wr_req(MAT_D, 2'd0, 2'd1, 24'sh800000), 1'b0, 0, 0);
    queue_req(wr_req(MAT_D, 2'd1, 2'd0, 24'sh100000), 1'b0, 0, 0);
    queue_req(wr_req(MAT_B, 2'd1, 2'd2, 24'sh7fffff), 1'b0, 0, 0);
    queue_req(wr_req(MAT_C, 2'd2, 2'd0, 24'sh7fffff), 1'b0, 0, 0);
    queue_req(wr_req(MAT_D, 2'd3, 2'd3, 24'sh7fffff), 1'b0, 0, 0);
    queue_req(smp_req(32'sh0, 32'sh0), 1'b0, 0, 0);
    queue_req(smp_req(32'sh7fffffff, 32'sh80000000), 1'b0, 0, 0);
    queue_req(smp_req(32'sh80000000, 32'sh7fffffff), 1'b0, 0, 0);
    queue_req(smp_req(32'sh80000000, 32'sh80000000), 1'b0, 0, 0);
    queue_req(make_req(FN_UNUSED), 1'b0, 0, 0);
    queue_req(make_req(FN_CLEAR), 1'b0, 0, 0);
    queue_req(smp_req(32'sh00010000, -32'sh00010000), 1'b0, 0, 0);
    queue_req(smp_req(32'sh00000001, 32'shffffffff), 1'b0, 0, 0);
    queue_req(make_req(FN_CLEAR), 1'b0, 0, 0);
    queue_req(smp_req(32'sh00080000, 32'sh00000000), 1'b0, 0, 0);

    // Random phases: free-running, sender idle, receiver stall, both
    queue_phase(0, 0);
    queue_phase(85, 0);
    queue_phase(0, 85);
    queue_phase(32, 32);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (expected_y.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
